### src/b2dd_pkg.sv
package b2dd_pkg;

  localparam int unsigned NumNibbles = 8;
  localparam int unsigned NumPos     = 9;
  localparam int unsigned NibW       = 4;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned SumW       = 10;
  localparam int unsigned CarryW     = 7;
  localparam int unsigned TopW       = 3;
  localparam int unsigned ValueW     = NumNibbles * NibW;
  localparam int unsigned RecipMul   = 205;
  localparam int unsigned RecipShift = 11;
  localparam int unsigned ProdW      = SumW + 8;

  // Decimal digit p (row) of 16^k (column).
  localparam logic [NibW-1:0] WeightTab [NumPos][NumNibbles] = '{
    '{4'd1, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
    '{4'd0, 4'd1, 4'd5, 4'd9, 4'd3, 4'd7, 4'd1, 4'd5},
    '{4'd0, 4'd0, 4'd2, 4'd0, 4'd5, 4'd5, 4'd2, 4'd4},
    '{4'd0, 4'd0, 4'd0, 4'd4, 4'd5, 4'd8, 4'd7, 4'd5},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd4, 4'd7, 4'd3},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd7, 4'd4},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd6, 4'd8},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd6},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd2}
  };

  typedef struct packed {
    logic [ValueW-1:0]             value;
    logic [CarryW-1:0]             carry;
    logic [NumPos-1:0][DigitW-1:0] digits;
  } cell_word_t;

endpackage

### src/b2dd_cell.sv
module b2dd_cell import b2dd_pkg::*; #(
  parameter int unsigned Pos = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  cell_word_t word_i,
  output logic       stall_o,
  output logic       valid_o,
  output cell_word_t word_o,
  input  logic       stall_i
);

  logic              valid_q;
  cell_word_t        word_q;
  cell_word_t        word_d;
  logic [SumW-1:0]   sum;
  logic [ProdW-1:0]  prod;
  logic [CarryW-1:0] quot;
  logic [SumW-1:0]   rem;
  logic              advance;

  always_comb begin
    sum = SumW'(word_i.carry);
    for (int k = 0; k < NumNibbles; k++) begin
      sum = sum + SumW'(word_i.value[k*NibW +: NibW]) * SumW'(WeightTab[Pos][k]);
    end
  end

  // sum / 10 by reciprocal, exact below 1029
  assign prod = ProdW'(sum) * ProdW'(RecipMul);
  assign quot = prod[RecipShift +: CarryW];
  assign rem  = sum - SumW'(quot) * SumW'(4'd10);

  always_comb begin
    word_d             = word_i;
    word_d.carry       = quot;
    word_d.digits[Pos] = rem[DigitW-1:0];
  end

  assign stall_o = valid_q && stall_i;
  assign advance = !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### src/binary32_to_decimal_digits.sv
// Converts an unsigned 32-bit word to its ten decimal digits, leading zeros kept.
// The word runs through a chain of nine cells, one per decimal position from the
// ones upward; each cell adds the nibbles weighted by the digits of 16^k to the
// carry from below, keeps the sum modulo ten and hands the quotient up. The top
// digit is the carry out of the last cell. Each cell registers the word, so a
// result reaches the output from the register of the last cell once it has passed
// through them all; a new word is taken every cycle while the output is not stalled,
// and a stall on the output holds the chain back cell by cell.
module binary32_to_decimal_digits import b2dd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ValueW-1:0]   value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DigitW-1:0]   digit_ones_o,
  output logic [DigitW-1:0]   digit_tens_o,
  output logic [DigitW-1:0]   digit_hundreds_o,
  output logic [DigitW-1:0]   digit_thousands_o,
  output logic [DigitW-1:0]   digit_e4_o,
  output logic [DigitW-1:0]   digit_e5_o,
  output logic [DigitW-1:0]   digit_e6_o,
  output logic [DigitW-1:0]   digit_e7_o,
  output logic [DigitW-1:0]   digit_e8_o,
  output logic [TopW-1:0]     digit_e9_o
);

  logic       valid [NumPos+1];
  logic       stall [NumPos+1];
  cell_word_t word  [NumPos+1];

  always_comb begin
    word[0]        = '0;
    word[0].value  = value_i;
  end

  assign valid[0]       = in_valid_i;
  assign in_stall_o     = stall[0];
  assign stall[NumPos]  = out_stall_i;

  for (genvar p = 0; p < NumPos; p++) begin : g_cell
    b2dd_cell #(
      .Pos(p)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[p]),
      .word_i (word[p]),
      .stall_o(stall[p]),
      .valid_o(valid[p+1]),
      .word_o (word[p+1]),
      .stall_i(stall[p+1])
    );
  end

  assign out_valid_o       = valid[NumPos];
  assign digit_ones_o      = word[NumPos].digits[0];
  assign digit_tens_o      = word[NumPos].digits[1];
  assign digit_hundreds_o  = word[NumPos].digits[2];
  assign digit_thousands_o = word[NumPos].digits[3];
  assign digit_e4_o        = word[NumPos].digits[4];
  assign digit_e5_o        = word[NumPos].digits[5];
  assign digit_e6_o        = word[NumPos].digits[6];
  assign digit_e7_o        = word[NumPos].digits[7];
  assign digit_e8_o        = word[NumPos].digits[8];
  assign digit_e9_o        = word[NumPos].carry[TopW-1:0];

endmodule

### sim/b2dd_digit_compare.sv
`timescale 1ns / 100ps

module b2dd_digit_compare import b2dd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [DigitW-1:0] digit_ones_i,
  input  logic [DigitW-1:0] digit_tens_i,
  input  logic [DigitW-1:0] digit_hundreds_i,
  input  logic [DigitW-1:0] digit_thousands_i,
  input  logic [DigitW-1:0] digit_e4_i,
  input  logic [DigitW-1:0] digit_e5_i,
  input  logic [DigitW-1:0] digit_e6_i,
  input  logic [DigitW-1:0] digit_e7_i,
  input  logic [DigitW-1:0] digit_e8_i,
  input  logic [TopW-1:0]   digit_e9_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int unsigned NumDigits = NumPos + 1;

  typedef logic [NumDigits-1:0][DigitW-1:0] digit_set_t;

  localparam string DigitName [NumDigits] = '{
    "digit_ones", "digit_tens", "digit_hundreds", "digit_thousands", "digit_e4",
    "digit_e5", "digit_e6", "digit_e7", "digit_e8", "digit_e9"
  };

  digit_set_t pending_digits [$];
  int         fail_count;

  function automatic digit_set_t to_decimal_digits(input logic [ValueW-1:0] word);
    digit_set_t                digits;
    logic       [ValueW-1:0]   rest;
    rest = word;
    for (int p = 0; p < NumDigits; p++) begin
      digits[p] = DigitW'(rest % 10);
      rest      = rest / 10;
    end
    return digits;
  endfunction

  initial begin
    fail_count   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    digit_set_t got;
    digit_set_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        pending_digits.push_back(to_decimal_digits(value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = {DigitW'(digit_e9_i), digit_e8_i, digit_e7_i, digit_e6_i, digit_e5_i,
               digit_e4_i, digit_thousands_i, digit_hundreds_i, digit_tens_i,
               digit_ones_i};
        if (pending_digits.size() == 0) begin
          $error("unexpected word on output: %0d%0d%0d%0d%0d%0d%0d%0d%0d%0d",
                 got[9], got[8], got[7], got[6], got[5], got[4], got[3], got[2],
                 got[1], got[0]);
          fail_count++;
        end else begin
          want = pending_digits.pop_front();
          for (int p = 0; p < NumDigits; p++) begin
            if (got[p] !== want[p]) begin
              $error("%s: expected %0d, actual %0d", DigitName[p], want[p], got[p]);
              fail_count++;
            end
          end
        end
      end
      fail_count_o <= fail_count;
      pending_o    <= pending_digits.size();
    end
  end

endmodule

### sim/binary32_to_decimal_digits_tb.sv
`timescale 1ns / 100ps

module binary32_to_decimal_digits_tb;
  import b2dd_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int RandomPerRun = 650;
  localparam int DrainCycles  = 20;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] value     = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DigitW-1:0] digit_ones;
  logic [DigitW-1:0] digit_tens;
  logic [DigitW-1:0] digit_hundreds;
  logic [DigitW-1:0] digit_thousands;
  logic [DigitW-1:0] digit_e4;
  logic [DigitW-1:0] digit_e5;
  logic [DigitW-1:0] digit_e6;
  logic [DigitW-1:0] digit_e7;
  logic [DigitW-1:0] digit_e8;
  logic [TopW-1:0]   digit_e9;

  int fail_count;
  int pending_words;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary32_to_decimal_digits u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .value_i           (value),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .digit_ones_o      (digit_ones),
    .digit_tens_o      (digit_tens),
    .digit_hundreds_o  (digit_hundreds),
    .digit_thousands_o (digit_thousands),
    .digit_e4_o        (digit_e4),
    .digit_e5_o        (digit_e5),
    .digit_e6_o        (digit_e6),
    .digit_e7_o        (digit_e7),
    .digit_e8_o        (digit_e8),
    .digit_e9_o        (digit_e9)
  );

  b2dd_digit_compare u_compare (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .value_i           (value),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .digit_ones_i      (digit_ones),
    .digit_tens_i      (digit_tens),
    .digit_hundreds_i  (digit_hundreds),
    .digit_thousands_i (digit_thousands),
    .digit_e4_i        (digit_e4),
    .digit_e5_i        (digit_e5),
    .digit_e6_i        (digit_e6),
    .digit_e7_i        (digit_e7),
    .digit_e8_i        (digit_e8),
    .digit_e9_i        (digit_e9),
    .fail_count_o      (fail_count),
    .pending_o         (pending_words)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [ValueW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [ValueW-1:0] power_of_ten(input int exponent);
    logic [ValueW-1:0] acc;
    acc = 1;
    for (int i = 0; i < exponent; i++) acc = acc * 10;
    return acc;
  endfunction

  function automatic logic [ValueW-1:0] random_word();
    logic [ValueW-1:0] word;
    logic [63:0]       acc;
    word = '0;
    acc  = '0;
    case ($urandom_range(5))
      0, 1: word = $urandom;
      2: word = $urandom_range(9999);
      3: word = power_of_ten($urandom_range(1, 9)) + ValueW'($urandom_range(6)) - 3;
      4: begin
        for (int p = 0; p < NumPos + 1; p++) acc = acc * 10 + $urandom_range(9);
        word = acc[ValueW-1:0];
      end
      default: begin
        for (int k = 0; k < NumNibbles; k++) begin
          case ($urandom_range(2))
            0: word[k*NibW +: NibW] = '0;
            1: word[k*NibW +: NibW] = '1;
            default: word[k*NibW +: NibW] = NibW'($urandom);
          endcase
        end
      end
    endcase
    return word;
  endfunction

  localparam logic [ValueW-1:0] EdgeWords [22] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd15, 32'd16, 32'd99, 32'd100,
    32'd999999999, 32'd1000000000, 32'd3999999999, 32'd4000000000,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd4294967290, 32'd2147483648
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 12;
    recv_idle_pct <= 55;
    foreach (EdgeWords[i]) send_word(EdgeWords[i]);
    repeat (RandomPerRun) send_word(random_word());

    send_idle_pct <= 55;
    recv_idle_pct <= 12;
    repeat (RandomPerRun) send_word(random_word());

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    repeat (RandomPerRun) send_word(random_word());
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_words != 0);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
